@@ hdl/stbs_pkg.sv @@
package stbs_pkg;

  // field widths of the channels and the register
  localparam int CMD_W   = 1;
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;
  localparam int POS_W   = 10;

  // operation carried by an input word
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COMPARE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;       // store the input word in the table
    logic start;    // take the target and set the bounds
    logic rd;       // read the entry at the probe
    logic step;     // move one bound past the probe
    logic capture;  // note a hit at the probe
    logic finish;   // load the result word
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bounds_ok;  // low not above high
    logic hit;        // probed entry equals target
    logic out_busy;   // result word waits and is not taken
  } dp_status_t;

endpackage

@@ hdl/stbs_if.sv @@
// input channel
interface stbs_in_if;
  import stbs_pkg::*;

  logic                      valid;
  logic                      ready;
  cmd_t                      cmd;
  logic [INDEX_W-1:0]        entry_index;
  logic signed [VALUE_W-1:0] item_value;

  modport source (output valid, output cmd, output entry_index, output item_value,
                  input ready);
  modport sink   (input valid, input cmd, input entry_index, input item_value,
                  output ready);
endinterface

// result channel
interface stbs_out_if;
  import stbs_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink   (input valid, input found, input position, output ready);
endinterface

@@ hdl/sorted_table_binary_search_top.sv @@
// channel   dir  payload                               word moved when
// in_if     in   cmd, entry_index, item_value          valid && ready
// out_if    out  found, position                       valid && ready
// cfg       in   cfg_data (entry count)                cfg_we
//
// a write word is stored as it is taken; a search runs a table read and a compare for
// each probe and loads its result word after the compare that hits, or on a miss after
// the check that finds the bounds crossed; at most log2(TABLE_DEPTH) + 1 probes.
// the result waits in an output register; the next word is taken once it is loaded.
// a stalled result holds the search in its last state until the output is free.
// rst_n clears the entry count and the control; the table itself is not cleared.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0] cfg_data,
  stbs_in_if.sink                      in_if,
  stbs_out_if.source                   out_if
);
  import stbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller
  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_cmd   (in_if.cmd),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath with the table
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_entry_index (in_if.entry_index),
    .in_item_value  (in_if.item_value),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_if.valid),
    .out_ready      (out_if.ready),
    .out_found      (out_if.found),
    .out_position   (out_if.position)
  );

endmodule

@@ hdl/stbs_ram.sv @@
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/stbs_ctrl.sv @@
module stbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  stbs_pkg::cmd_t       in_cmd,
  output logic                 in_ready,
  input  stbs_pkg::dp_status_t status,
  output stbs_pkg::dp_cmd_t    cmd
);
  import stbs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_SEARCH) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.bounds_ok ? ST_COMPARE : ST_DONE;
      end
      ST_COMPARE: begin
        state_nxt = status.hit ? ST_DONE : ST_CHECK;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_SEARCH) begin
            cmd.start = 1'b1;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        cmd.rd = status.bounds_ok;
      end
      ST_COMPARE: begin
        if (status.hit) begin
          cmd.capture = 1'b1;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hdl/stbs_dp.sv @@
module stbs_dp #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data,
  input  logic [stbs_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_item_value,
  input  stbs_pkg::dp_cmd_t                   cmd,
  output stbs_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [stbs_pkg::POS_W-1:0]          out_position
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  // bounds span -1 .. TABLE_DEPTH
  localparam int BW = AW + 2;

  logic [COUNT_W-1:0]        count_r;
  logic signed [VALUE_W-1:0] target_r;
  logic signed [BW-1:0]      low_r;
  logic signed [BW-1:0]      high_r;
  logic signed [BW-1:0]      high_init;
  logic signed [BW-1:0]      diff;
  logic signed [BW-1:0]      probe;
  logic                      found_r;
  logic [POS_W-1:0]          pos_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [POS_W-1:0]          out_pos_r;
  logic                      wr_en;
  logic [VALUE_W-1:0]        rd_data;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_we) begin
      count_r <= cfg_data;
    end
  end

  // top bound, count saturated to the table depth
  always_comb begin
    if (int'(count_r) > TABLE_DEPTH) begin
      high_init = BW'(TABLE_DEPTH - 1);
    end else begin
      high_init = BW'(count_r) - BW'(1);
    end
  end

  // probe at the middle of the bounds
  assign diff  = high_r - low_r;
  assign probe = low_r + (diff >>> 1);

  // table, writes beyond the depth dropped
  assign wr_en = cmd.wr && (int'(in_entry_index) < TABLE_DEPTH);

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_entry_index)),
    .wdata (in_item_value),
    .re    (cmd.rd),
    .raddr (probe[AW-1:0]),
    .rdata (rd_data)
  );

  // bounds and target
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      target_r <= in_item_value;
      low_r    <= '0;
      high_r   <= high_init;
    end else if (cmd.step) begin
      if ($signed(rd_data) < target_r) begin
        low_r <= probe + BW'(1);
      end else begin
        high_r <= probe - BW'(1);
      end
    end
  end

  // search outcome
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      found_r <= 1'b0;
      pos_r   <= '0;
    end else if (cmd.capture) begin
      found_r <= 1'b1;
      pos_r   <= POS_W'(probe);
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_found_r <= found_r;
      out_pos_r   <= pos_r;
    end
  end

  assign status.bounds_ok = (low_r <= high_r);
  assign status.hit       = ($signed(rd_data) == target_r);
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule
